/* rtl/assert_macros.svh */
// assertion helpers, clock clk and active low reset rst_n assumed in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define RTCM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in rolling trace column mapper");

`define RTCM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in rolling trace column mapper");

`endif

/* rtl/rtcm_pkg.sv */
package rtcm_pkg;

    localparam int STORE_DEPTH = 2048;
    localparam int PLOT_WIDTH  = 200;
    localparam int PLOT_HEIGHT = 160;

    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);

    localparam int SAMPLE_W = 32;
    localparam int COL_W    = 8;
    localparam int ROW_W    = 8;
    localparam int SPP_W    = 12;
    localparam int RPU_W    = 17;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    // horizontal zoom is Q4.8, age rounds half up
    localparam int SPP_FRAC   = 8;
    localparam int APROD_W    = COL_W + SPP_W;
    localparam int AGE_W      = APROD_W + 1 - SPP_FRAC;
    localparam int CMP_W      = (AGE_W > CNT_W) ? AGE_W : CNT_W;

    // row offset is a Q.20 product
    localparam int DIFF_W  = SAMPLE_W + 1;
    localparam int PROD_W  = DIFF_W + RPU_W + 1;
    localparam int ROW_FRAC = 20;
    localparam int OFF_W   = PROD_W - ROW_FRAC;

    localparam logic KIND_PUSH  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_PIXEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_PER_UNIT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_VALUE      = 2'd2;

    localparam logic [SPP_W-1:0]    SPP_RESET    = SPP_W'(128);
    localparam logic [RPU_W-1:0]    RPU_RESET    = RPU_W'(9600);
    localparam logic [SAMPLE_W-1:0] CENTER_RESET = '0;

    typedef struct packed {
        logic                kind;
        logic [SAMPLE_W-1:0] target_sample;
        logic [SAMPLE_W-1:0] actual_sample;
        logic [COL_W-1:0]    column;
    } item_t;

    typedef struct packed {
        logic [COL_W-1:0] column_out;
        logic             has_sample;
        logic [ROW_W-1:0] target_row;
        logic [ROW_W-1:0] actual_row;
        logic             join_previous;
        logic [ROW_W-1:0] previous_target_row;
        logic [ROW_W-1:0] previous_actual_row;
    } result_t;

    typedef struct packed {
        logic                push;
        logic [SAMPLE_W-1:0] target_sample;
        logic [SAMPLE_W-1:0] actual_sample;
        logic                read;
        logic [IDX_W-1:0]    age;
    } store_req_t;

endpackage

/* rtl/rtcm_store.sv */
module rtcm_store
    import rtcm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  store_req_t          req,
    output logic [SAMPLE_W-1:0] target_q,
    output logic [SAMPLE_W-1:0] actual_q,
    output logic [CNT_W-1:0]    count
);

    logic [SAMPLE_W-1:0] target_mem [STORE_DEPTH];
    logic [SAMPLE_W-1:0] actual_mem [STORE_DEPTH];

    logic [IDX_W-1:0] newest_reg;
    logic [IDX_W-1:0] newest_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W:0]   wrap_sum;
    logic [IDX_W-1:0] rd_idx;

    always_comb
    begin
        newest_next = newest_reg;
        count_next  = count_reg;
        if (req.push)
        begin
            if (count_reg == '0)
                newest_next = '0;
            else if (newest_reg == IDX_W'(STORE_DEPTH - 1))
                newest_next = '0;
            else
                newest_next = newest_reg + IDX_W'(1);
            if (count_reg < CNT_W'(STORE_DEPTH))
                count_next = count_reg + CNT_W'(1);
        end
    end

    // walk back from the newest entry, wrapping around the ring
    always_comb
    begin
        if (newest_reg >= req.age)
            wrap_sum = {1'b0, newest_reg} - {1'b0, req.age};
        else
            wrap_sum = {1'b0, newest_reg} + (IDX_W + 1)'(STORE_DEPTH) - {1'b0, req.age};
        rd_idx = wrap_sum[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newest_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            newest_reg <= newest_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            target_mem[newest_next] <= req.target_sample;
            actual_mem[newest_next] <= req.actual_sample;
        end
        if (req.read)
        begin
            target_q <= target_mem[rd_idx];
            actual_q <= actual_mem[rd_idx];
        end
    end

    assign count = count_reg;

endmodule

/* rtl/rtcm_row_map.sv */
module rtcm_row_map
    import rtcm_pkg::*;
(
    input  logic                clk,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [SAMPLE_W-1:0] center,
    input  logic [RPU_W-1:0]    rows_per_unit,
    output logic [ROW_W-1:0]    row
);

    localparam logic signed [OFF_W-1:0] MID_ROW = OFF_W'(PLOT_HEIGHT / 2);
    localparam logic signed [OFF_W-1:0] LOW_OFF = OFF_W'(PLOT_HEIGHT / 2) - OFF_W'(PLOT_HEIGHT - 1);

    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [DIFF_W-1:0] diff_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] biased;
    logic signed [OFF_W-1:0]  off;
    logic [ROW_W-1:0]         row_reg;
    logic [ROW_W-1:0]         row_next;

    always_comb
    begin
        diff_next = $signed({sample[SAMPLE_W-1], sample}) - $signed({center[SAMPLE_W-1], center});
        prod_next = diff_reg * $signed({1'b0, rows_per_unit});
    end

    // truncate toward zero, then clamp into the plot
    always_comb
    begin
        biased = prod_reg + $signed({{(PROD_W - ROW_FRAC){1'b0}}, {ROW_FRAC{prod_reg[PROD_W-1]}}});
        off    = biased[PROD_W-1:ROW_FRAC];
        priority if (off > MID_ROW)
            row_next = '0;
        else if (off < LOW_OFF)
            row_next = ROW_W'(PLOT_HEIGHT - 1);
        else
            row_next = ROW_W'(MID_ROW - off);
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        prod_reg <= prod_next;
        row_reg  <= row_next;
    end

    assign row = row_reg;

endmodule

/* rtl/rolling_trace_column_mapper_core.sv */
// Rolling two-trace plot column mapper. A push transaction (kind 0) stores a target and actual
// sample pair in a 2048-entry ring; pushes are accepted back to back and give no result. A query
// transaction (kind 1) maps a plot column to a sample age, reads the ring and returns the two
// clamped plot rows plus the previous column's rows and a join flag. A query occupies the block
// from acceptance until its result is loaded into the output register: age multiply, age compare
// and ring addressing, ring memory read, sample difference, zoom multiply, then rounding and
// clamping. The next transaction is accepted in the cycle after that load; while the output
// register holds an untaken result the query waits in its last step. Ring entries have no reset
// and need no clearing pass after reset. The user must write configuration through cfg_we,
// cfg_index and cfg_data only while no query is in flight; the block does not enforce this.
`include "assert_macros.svh"

module rolling_trace_column_mapper_core
    import rtcm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_AGE  = 3'd1;
    localparam logic [2:0] S_ADDR = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_DIFF = 3'd4;
    localparam logic [2:0] S_PROD = 3'd5;
    localparam logic [2:0] S_ROW  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    logic [SPP_W-1:0]    spp_reg;
    logic [RPU_W-1:0]    rpu_reg;
    logic [SAMPLE_W-1:0] center_reg;

    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   dx_reg;
    logic               in_range_reg;
    logic [APROD_W-1:0] aprod_reg;
    logic [AGE_W-1:0]   age;
    logic [APROD_W:0]   age_sum;
    logic               hit_reg;
    logic               hit_next;

    logic             prev_valid_reg;
    logic             prev_valid_next;
    logic [ROW_W-1:0] prev_target_reg;
    logic [ROW_W-1:0] prev_actual_reg;

    logic    result_valid_reg;
    logic    result_valid_next;
    result_t result_reg;
    result_t result_next;

    logic                item_take;
    logic                load;
    store_req_t          store_req;
    logic [SAMPLE_W-1:0] target_q;
    logic [SAMPLE_W-1:0] actual_q;
    logic [CNT_W-1:0]    count;
    logic [ROW_W-1:0]    target_row;
    logic [ROW_W-1:0]    actual_row;

    assign item_ready = (state_reg == S_IDLE);
    assign item_take  = item_valid && item_ready;
    assign load       = (state_reg == S_ROW) && (!result_valid_reg || result_ready);

    always_comb
    begin
        age_sum = {1'b0, aprod_reg} + (APROD_W + 1)'(1 << (SPP_FRAC - 1));
        age     = age_sum[APROD_W:SPP_FRAC];
        hit_next = in_range_reg && (CMP_W'(age) < CMP_W'(count));
    end

    always_comb
    begin
        store_req.push          = item_take && (item.kind == KIND_PUSH);
        store_req.target_sample = item.target_sample;
        store_req.actual_sample = item.actual_sample;
        store_req.read          = (state_reg == S_ADDR);
        store_req.age           = IDX_W'(age);
    end

    rtcm_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (store_req),
        .target_q (target_q),
        .actual_q (actual_q),
        .count    (count)
    );

    rtcm_row_map u_target_row (
        .clk           (clk),
        .sample        (target_q),
        .center        (center_reg),
        .rows_per_unit (rpu_reg),
        .row           (target_row)
    );

    rtcm_row_map u_actual_row (
        .clk           (clk),
        .sample        (actual_q),
        .center        (center_reg),
        .rows_per_unit (rpu_reg),
        .row           (actual_row)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_take && (item.kind == KIND_QUERY))
                    state_next = S_AGE;
            end
            S_AGE:  state_next = S_ADDR;
            S_ADDR: state_next = S_READ;
            S_READ: state_next = S_DIFF;
            S_DIFF: state_next = S_PROD;
            S_PROD: state_next = S_ROW;
            S_ROW:
            begin
                if (load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // result assembly and join tracking
    always_comb
    begin
        result_next     = result_reg;
        prev_valid_next = prev_valid_reg;
        result_valid_next = result_valid_reg;
        if (result_ready)
            result_valid_next = 1'b0;
        if (load)
        begin
            result_valid_next = 1'b1;
            result_next = '0;
            result_next.column_out = col_reg;
            if (hit_reg)
            begin
                result_next.has_sample = 1'b1;
                result_next.target_row = target_row;
                result_next.actual_row = actual_row;
                if (prev_valid_reg && (col_reg != '0))
                begin
                    result_next.join_previous       = 1'b1;
                    result_next.previous_target_row = prev_target_reg;
                    result_next.previous_actual_row = prev_actual_reg;
                end
                prev_valid_next = 1'b1;
            end
            else
                prev_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            prev_valid_reg   <= 1'b0;
            prev_target_reg  <= '0;
            prev_actual_reg  <= '0;
            spp_reg          <= SPP_RESET;
            rpu_reg          <= RPU_RESET;
            center_reg       <= CENTER_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            prev_valid_reg   <= prev_valid_next;
            if (load && hit_reg)
            begin
                prev_target_reg <= target_row;
                prev_actual_reg <= actual_row;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SAMPLES_PER_PIXEL: spp_reg    <= cfg_data[SPP_W-1:0];
                    REG_ROWS_PER_UNIT:     rpu_reg    <= cfg_data[RPU_W-1:0];
                    REG_CENTER_VALUE:      center_reg <= cfg_data[SAMPLE_W-1:0];
                    default:               ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            col_reg      <= item.column;
            in_range_reg <= (item.column < PLOT_WIDTH);
            dx_reg       <= COL_W'(PLOT_WIDTH - 1) - item.column;
        end
        if (state_reg == S_AGE)
            aprod_reg <= dx_reg * spp_reg;
        if (state_reg == S_ADDR)
            hit_reg <= hit_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `RTCM_ASSERT_NOW(a_join_needs_sample, result_valid, !result.join_previous || result.has_sample)
    `RTCM_ASSERT_NOW(a_empty_rows_zero, result_valid && !result.has_sample, (result.target_row == '0) && (result.actual_row == '0) && !result.join_previous)
    `RTCM_ASSERT_NOW(a_rows_in_plot, result_valid, (result.target_row < PLOT_HEIGHT) && (result.actual_row < PLOT_HEIGHT))
    `RTCM_ASSERT_NEXT(a_push_counts, item_valid && item_ready && (item.kind == KIND_PUSH), count != '0)

endmodule
